// ===== src/rhc_pkg.sv =====
// Shared constants and types for the RGB/HSV pixel converter.
// No dependencies; the converter, both datapaths and the testbench import this package.
package rhc_pkg;

	typedef enum logic {
		OP_TO_HSV = 1'b0,
		OP_TO_RGB = 1'b1
	} op_t;

	localparam int unsigned HUE_SPAN    = 180;
	localparam int unsigned SECTOR_SPAN = 30;
	localparam int unsigned FRAC_SCALE  = 7650;   // 255 * 30

	// Reciprocal for 16-bit numerators over 8-bit divisors.
	localparam int unsigned RECIP_SHIFT = 16;
	localparam int unsigned RECIP_NUM   = 65536;

	// Reciprocals for the constant divisors of the HSV to RGB path.
	localparam logic [16:0] RECIP_255   = 17'd65793;   // floor(2^24 / 255)
	localparam int unsigned SHIFT_255   = 24;
	localparam logic [8:0]  RECIP_7650  = 9'd274;      // floor(2^21 / 7650)
	localparam int unsigned SHIFT_7650  = 21;

	localparam int unsigned DEPTH = 5;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} pix_t;

	// Start of each hue sector in halved degrees.
	function automatic logic [7:0] sector_base(input logic [2:0] sec);
		logic [7:0] base;
		unique case (sec)
			3'd0:    base = 8'd0;
			3'd1:    base = 8'd30;
			3'd2:    base = 8'd60;
			3'd3:    base = 8'd90;
			3'd4:    base = 8'd120;
			default: base = 8'd150;
		endcase
		return base;
	endfunction

endpackage

// ===== src/rgb_hsv_color_converter.sv =====
// Top level of the RGB/HSV pixel converter: valid bits, stall control, result select.
// Depends on rhc_pkg, rhc_hsv_unit and rhc_rgb_unit.
//
// This block converts one 8-bit pixel per clock between RGB and HSV, with hue in
// halved degrees (0..179). A beat with operation 0 takes red, green and blue on
// color_a..color_c and returns hue, saturation and value; operation 1 takes hue,
// saturation and value and returns red, green and blue. Hue inputs of 180 or
// more wrap around. All arithmetic is exact integer math with truncation.
// The pipeline is five stages deep, and a new beat can be accepted every
// cycle while the sink keeps up. The whole pipeline advances together: when
// the final stage holds a result that the sink does not take, pix_ready drops
// and every stage holds, so nothing is lost or repeated. The final stage is
// the output register. Results leave in the order the beats arrived. There
// are no configuration registers and no state is carried from one pixel to
// the next.
module rgb_hsv_color_converter
	import rhc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  logic       operation,
	input  logic [7:0] color_a,
	input  logic [7:0] color_b,
	input  logic [7:0] color_c,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] result_a,
	output logic [7:0] result_b,
	output logic [7:0] result_c
);

	logic en;
	logic [DEPTH-1:0] vld_q;
	op_t              op_q [DEPTH];
	pix_t             pix, hsv_res, rgb_res;

	// The pipeline moves whenever the final stage is empty or being drained.
	assign en        = !vld_q[DEPTH-1] || res_ready;
	assign pix_ready = en;
	assign pix       = '{a: color_a, b: color_b, c: color_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], pix_valid};
		end
	end

	// The operation code travels beside the data to pick the result.
	always_ff @(posedge clk) begin
		if (en) begin
			op_q[0] <= op_t'(operation);
			for (int k = 1; k < DEPTH; k++) begin
				op_q[k] <= op_q[k-1];
			end
		end
	end

	rhc_hsv_unit u_hsv (
		.clk (clk),
		.en  (en),
		.pix (pix),
		.res (hsv_res)
	);

	rhc_rgb_unit u_rgb (
		.clk (clk),
		.en  (en),
		.pix (pix),
		.res (rgb_res)
	);

	assign res_valid = vld_q[DEPTH-1];
	assign result_a  = (op_q[DEPTH-1] == OP_TO_RGB) ? rgb_res.a : hsv_res.a;
	assign result_b  = (op_q[DEPTH-1] == OP_TO_RGB) ? rgb_res.b : hsv_res.b;
	assign result_c  = (op_q[DEPTH-1] == OP_TO_RGB) ? rgb_res.c : hsv_res.c;

endmodule

// ===== src/rhc_hsv_unit.sv =====
// RGB to HSV datapath, five register stages with a shared stage enable.
// Depends on rhc_pkg.
module rhc_hsv_unit
	import rhc_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  pix_t pix,
	output pix_t res
);

	// Reciprocal table: floor(2^16 / d), entry zero unused.
	logic [16:0] recip_lut [256];
	assign recip_lut[0] = '0;
	for (genvar i = 1; i < 256; i++) begin : g_lut
		localparam logic [16:0] RV = 17'(RECIP_NUM / i);
		assign recip_lut[i] = RV;
	end

	// Stage 1: max, min, range and hue numerator.
	logic [7:0]         mx, mn, rng;
	logic signed [18:0] num;
	always_comb begin
		logic signed [18:0] ra, ga, ba, rg;
		ra = 19'(pix.a);
		ga = 19'(pix.b);
		ba = 19'(pix.c);
		mx = (pix.a > pix.b) ? pix.a : pix.b;
		mx = (mx > pix.c) ? mx : pix.c;
		mn = (pix.a < pix.b) ? pix.a : pix.b;
		mn = (mn < pix.c) ? mn : pix.c;
		rng = mx - mn;
		rg = 19'(rng);
		// Ties resolve toward red, then green.
		if (mx == pix.a) begin
			num = 19'sd60 * (ga - ba);
		end else if (mx == pix.b) begin
			num = 19'sd60 * (ba - ra) + 19'sd120 * rg;
		end else begin
			num = 19'sd60 * (ra - ga) + 19'sd240 * rg;
		end
		if (num < 0) begin
			num = num + 19'sd360 * rg;
		end
	end

	logic [15:0] hnum_s1, snum_s1;
	logic [7:0]  rng_s1, mx_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			// Halving first leaves the floored quotient unchanged.
			hnum_s1 <= num[16:1];
			snum_s1 <= 16'(16'd255 * 16'(rng));
			rng_s1  <= rng;
			mx_s1   <= mx;
		end
	end

	// Stage 2: reciprocal estimates, low by at most one.
	logic [15:0] hq_s2, sq_s2, hnum_s2, snum_s2;
	logic [7:0]  rng_s2, mx_s2;
	always_ff @(posedge clk) begin
		logic [32:0] ph, ps;
		if (en) begin
			ph = 33'(hnum_s1) * 33'(recip_lut[rng_s1]);
			ps = 33'(snum_s1) * 33'(recip_lut[mx_s1]);
			hq_s2   <= ph[RECIP_SHIFT +: 16];
			sq_s2   <= ps[RECIP_SHIFT +: 16];
			hnum_s2 <= hnum_s1;
			snum_s2 <= snum_s1;
			rng_s2  <= rng_s1;
			mx_s2   <= mx_s1;
		end
	end

	// Stage 3: remainder check and grey handling.
	pix_t res_s3, res_s4, res_s5;
	always_ff @(posedge clk) begin
		logic [23:0] hr, sr;
		logic [15:0] hq, sq;
		if (en) begin
			hr = 24'(hnum_s2) - 24'(hq_s2) * 24'(rng_s2);
			sr = 24'(snum_s2) - 24'(sq_s2) * 24'(mx_s2);
			hq = hq_s2 + 16'(hr >= 24'(rng_s2));
			sq = sq_s2 + 16'(sr >= 24'(mx_s2));
			if (rng_s2 == 8'd0) begin
				res_s3.a <= 8'd0;
				res_s3.b <= 8'd0;
			end else begin
				res_s3.a <= hq[7:0];
				res_s3.b <= sq[7:0];
			end
			res_s3.c <= mx_s2;
		end
	end

	// Stages 4 and 5 align with the other datapath.
	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res_s3;
			res_s5 <= res_s4;
		end
	end

	assign res = res_s5;

endmodule

// ===== src/rhc_rgb_unit.sv =====
// HSV to RGB datapath, five register stages with a shared stage enable.
// Depends on rhc_pkg.
module rhc_rgb_unit
	import rhc_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  pix_t pix,
	output pix_t res
);

	// Stage 1: wrap hue, split into sector and fraction.
	logic [7:0] h;
	logic [2:0] sec;
	always_comb begin
		h = (pix.a >= 8'(HUE_SPAN)) ? pix.a - 8'(HUE_SPAN) : pix.a;
		sec = 3'd0;
		for (int k = 1; k < 6; k++) begin
			if (h >= 8'(k * SECTOR_SPAN)) begin
				sec = 3'(k);
			end
		end
	end

	logic [2:0] sec_s1, sec_s2, sec_s3, sec_s4;
	logic [4:0] fr_s1;
	logic [7:0] s_s1, v_s1, v_s2, v_s3, v_s4;
	always_ff @(posedge clk) begin
		logic [7:0] f;
		if (en) begin
			f = h - sector_base(sec);
			sec_s1 <= sec;
			fr_s1  <= f[4:0];
			s_s1   <= pix.b;
			v_s1   <= pix.c;
		end
	end

	// Stage 2: saturation times fraction and its complement.
	logic [12:0] sf_s2, sg_s2;
	logic [7:0]  ns_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sf_s2  <= 13'(s_s1) * 13'(fr_s1);
			sg_s2  <= 13'(s_s1) * 13'(5'(SECTOR_SPAN) - fr_s1);
			ns_s2  <= 8'd255 - s_s1;
			sec_s2 <= sec_s1;
			v_s2   <= v_s1;
		end
	end

	// Stage 3: numerators of p, q and t.
	logic [15:0] np_s3, np_s4;
	logic [20:0] nq_s3, nt_s3, nq_s4, nt_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			np_s3  <= 16'(v_s2) * 16'(ns_s2);
			nq_s3  <= 21'(v_s2) * (21'(FRAC_SCALE) - 21'(sf_s2));
			nt_s3  <= 21'(v_s2) * (21'(FRAC_SCALE) - 21'(sg_s2));
			sec_s3 <= sec_s2;
			v_s3   <= v_s2;
		end
	end

	// Stage 4: reciprocal estimates, low by at most one.
	logic [7:0] qp_s4, qq_s4, qt_s4;
	always_ff @(posedge clk) begin
		logic [32:0] pp;
		logic [29:0] pq, pt;
		if (en) begin
			pp = 33'(np_s3) * 33'(RECIP_255);
			pq = 30'(nq_s3) * 30'(RECIP_7650);
			pt = 30'(nt_s3) * 30'(RECIP_7650);
			qp_s4  <= pp[SHIFT_255 +: 8];
			qq_s4  <= pq[SHIFT_7650 +: 8];
			qt_s4  <= pt[SHIFT_7650 +: 8];
			np_s4  <= np_s3;
			nq_s4  <= nq_s3;
			nt_s4  <= nt_s3;
			sec_s4 <= sec_s3;
			v_s4   <= v_s3;
		end
	end

	// Stage 5: correct the estimates and route by sector.
	pix_t res_s5;
	always_ff @(posedge clk) begin
		logic [20:0] rp, rq, rt;
		logic [7:0]  p, q, t;
		if (en) begin
			rp = 21'(np_s4) - 21'(qp_s4) * 21'd255;
			rq = nq_s4 - 21'(qq_s4) * 21'(FRAC_SCALE);
			rt = nt_s4 - 21'(qt_s4) * 21'(FRAC_SCALE);
			p = qp_s4 + 8'(rp >= 21'd255);
			q = qq_s4 + 8'(rq >= 21'(FRAC_SCALE));
			t = qt_s4 + 8'(rt >= 21'(FRAC_SCALE));
			unique case (sec_s4)
				3'd0:    res_s5 <= '{a: v_s4, b: t,    c: p};
				3'd1:    res_s5 <= '{a: q,    b: v_s4, c: p};
				3'd2:    res_s5 <= '{a: p,    b: v_s4, c: t};
				3'd3:    res_s5 <= '{a: p,    b: q,    c: v_s4};
				3'd4:    res_s5 <= '{a: t,    b: p,    c: v_s4};
				default: res_s5 <= '{a: v_s4, b: p,    c: q};
			endcase
		end
	end

	assign res = res_s5;

endmodule

// ===== src/rhc_checker.sv =====
// Port-level checks for the pixel converter, bound to the top level.
// Depends on rgb_hsv_color_converter.
module rhc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] result_a,
	input logic [7:0] result_b,
	input logic [7:0] result_c
);

	// A result that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result_a)
			&& $stable(result_b) && $stable(result_c))
		else $error("stalled result changed");

	// Input is refused only while a finished result waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready == (!res_valid || res_ready))
		else $error("pix_ready does not follow output stall");

	// With the sink ready throughout, an accepted beat comes out as a valid result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) ##1 res_ready ##1 res_ready ##1 res_ready
			##1 res_ready |=> res_valid)
		else $error("result missing after pipeline latency");

endmodule

bind rgb_hsv_color_converter rhc_checker u_rhc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.result_a  (result_a),
	.result_b  (result_b),
	.result_c  (result_c)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the RGB/HSV pixel converter, with random idling on both sides.
// Depends on rhc_pkg and the rgb_hsv_color_converter RTL.
module tb
	import rhc_pkg::*;
;

	localparam int NUM_RANDOM  = 1500;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		op_t        op;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} pixel_t;

	logic       clk;
	logic       arst_n;
	logic       pix_valid;
	logic       pix_ready;
	logic       operation;
	logic [7:0] color_a;
	logic [7:0] color_b;
	logic [7:0] color_c;
	logic       res_valid;
	logic       res_ready;
	logic [7:0] result_a;
	logic [7:0] result_b;
	logic [7:0] result_c;

	pixel_t     pixel_q[$];     // pixels waiting to be driven
	pix_t       color_q[$];     // predicted colors, oldest first
	int         err_count = 0;
	bit         calm = 0;       // set for the last part of the run: no idling
	int         src_gap = 0;
	int         sink_gap = 0;
	int         quiet_cycles = 0;

	rgb_hsv_color_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.operation (operation),
		.color_a   (color_a),
		.color_b   (color_b),
		.color_c   (color_c),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.result_a  (result_a),
		.result_b  (result_b),
		.result_c  (result_c)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// RGB to HSV in exact integer math: value is the maximum, saturation
	// is 255*range/max, and hue is the sector formula in halved degrees.
	function automatic pix_t rgb_to_hsv(input int r, input int g, input int b);
		pix_t res;
		int   mx;
		int   mn;
		int   span;
		int   num;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		span = mx - mn;
		res = '0;
		res.c = mx[7:0];
		if (mx != 0 && span != 0) begin
			res.b = 8'((255 * span) / mx);
			// Red wins ties, then green, then blue.
			if (mx == r)
				num = 60 * (g - b);
			else if (mx == g)
				num = 60 * (b - r) + 120 * span;
			else
				num = 60 * (r - g) + 240 * span;
			if (num < 0)
				num += 360 * span;
			res.a = 8'(num / (2 * span));
		end
		return res;
	endfunction

	// HSV to RGB with the six-sector p/q/t rule; hue wraps at 180.
	function automatic pix_t hsv_to_rgb(input int hue, input int s, input int v);
		pix_t res;
		int   h;
		int   fr;
		int   p;
		int   q;
		int   t;
		h  = hue % 180;
		fr = h % 30;
		p  = (v * (255 - s)) / 255;
		q  = (v * (7650 - s * fr)) / 7650;
		t  = (v * (7650 - s * (30 - fr))) / 7650;
		case (h / 30)
			0: res = {8'(v), 8'(t), 8'(p)};
			1: res = {8'(q), 8'(v), 8'(p)};
			2: res = {8'(p), 8'(v), 8'(t)};
			3: res = {8'(p), 8'(q), 8'(v)};
			4: res = {8'(t), 8'(p), 8'(v)};
			default: res = {8'(v), 8'(p), 8'(q)};
		endcase
		return res;
	endfunction

	function automatic pix_t convert_pixel(input pixel_t px);
		if (px.op == OP_TO_HSV)
			return rgb_to_hsv(px.a, px.b, px.c);
		return hsv_to_rgb(px.a, px.b, px.c);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	task automatic add_pixel(input op_t op, input int a, input int b, input int c);
		pixel_t px;
		px.op = op;
		px.a  = 8'(a);
		px.b  = 8'(b);
		px.c  = 8'(c);
		pixel_q.push_back(px);
	endtask

	// Source side: hold a beat until it is taken, then idle in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			operation <= 1'b0;
			color_a   <= '0;
			color_b   <= '0;
			color_c   <= '0;
			src_gap   <= 0;
		end else begin
			if (pix_valid && pix_ready)
				color_q.push_back(convert_pixel({op_t'(operation), color_a, color_b,
					color_c}));
			if (!pix_valid || pix_ready) begin
				if (src_gap > 0) begin
					pix_valid <= 1'b0;
					src_gap   <= src_gap - 1;
				end else if (pixel_q.size() != 0) begin
					pixel_t px;
					px = pixel_q.pop_front();
					pix_valid <= 1'b1;
					operation <= px.op;
					color_a   <= px.a;
					color_b   <= px.b;
					color_c   <= px.c;
					if (!calm && $urandom_range(0, 7) == 0)
						src_gap <= $urandom_range(1, 8);
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Sink side: check every accepted result and stall in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			sink_gap  <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (color_q.size() == 0) begin
					report_mismatch("unexpected result", result_a, -1);
				end else begin
					pix_t want;
					want = color_q.pop_front();
					if (result_a !== want.a) report_mismatch("result_a", result_a, want.a);
					if (result_b !== want.b) report_mismatch("result_b", result_b, want.b);
					if (result_c !== want.c) report_mismatch("result_c", result_c, want.c);
				end
			end
			if (sink_gap > 0) begin
				res_ready <= 1'b0;
				sink_gap  <= sink_gap - 1;
			end else begin
				res_ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					sink_gap <= $urandom_range(1, 8);
			end
		end
	end

	// Watchdog: a long run of cycles with no beat on either side is a hang.
	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int op;
		arst_n = 1'b0;
		// Directed: extremes, grey and black pixels, ties for the maximum,
		// hue wrap, and each hue sector.
		add_pixel(OP_TO_HSV, 0, 0, 0);
		add_pixel(OP_TO_HSV, 255, 255, 255);
		add_pixel(OP_TO_HSV, 128, 128, 128);
		add_pixel(OP_TO_HSV, 255, 0, 0);
		add_pixel(OP_TO_HSV, 0, 255, 0);
		add_pixel(OP_TO_HSV, 0, 0, 255);
		add_pixel(OP_TO_HSV, 255, 255, 0);
		add_pixel(OP_TO_HSV, 0, 255, 255);
		add_pixel(OP_TO_HSV, 255, 0, 255);
		add_pixel(OP_TO_HSV, 255, 0, 1);
		add_pixel(OP_TO_HSV, 1, 0, 0);
		add_pixel(OP_TO_HSV, 170, 85, 85);
		add_pixel(OP_TO_RGB, 0, 0, 0);
		add_pixel(OP_TO_RGB, 0, 255, 255);
		add_pixel(OP_TO_RGB, 29, 255, 255);
		add_pixel(OP_TO_RGB, 30, 255, 255);
		add_pixel(OP_TO_RGB, 60, 255, 200);
		add_pixel(OP_TO_RGB, 90, 128, 255);
		add_pixel(OP_TO_RGB, 120, 255, 255);
		add_pixel(OP_TO_RGB, 179, 255, 255);
		add_pixel(OP_TO_RGB, 180, 255, 255);
		add_pixel(OP_TO_RGB, 255, 255, 255);
		add_pixel(OP_TO_RGB, 45, 0, 100);
		add_pixel(OP_TO_RGB, 200, 77, 0);
		for (int i = 0; i < NUM_RANDOM; i++) begin
			op = $urandom_range(0, 1);
			case ($urandom_range(0, 5))
				// Two equal channels exercise the tie rules.
				0: begin
					int v;
					v = $urandom_range(0, 255);
					add_pixel(op_t'(op), v, v, $urandom_range(0, 255));
				end
				1: add_pixel(op_t'(op), $urandom_range(0, 255), 255,
					$urandom_range(250, 255));
				default: add_pixel(op_t'(op), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255));
			endcase
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pixel_q.size() < 200);
		calm = 1;
		wait (pixel_q.size() == 0 && !pix_valid);
		wait (color_q.size() == 0);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
